// ===== sv/laser_scan_leg_detector_macros.svh =====
// Assertion macros for the leg detector checker
`ifndef LASER_SCAN_LEG_DETECTOR_MACROS_SVH
`define LASER_SCAN_LEG_DETECTOR_MACROS_SVH

`define LSLD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LSLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/lsld_pkg.sv =====
`timescale 1ns / 1ps
package lsld_pkg;

    localparam int MaxPoints = 1024;
    localparam int CntW = $clog2(MaxPoints + 1);
    localparam int IdxW = 10;
    localparam int CosSteps = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JUMP,
        ST_DIV,
        ST_CHK_MEAN,
        ST_MUL_RR1,
        ST_MUL_RR2,
        ST_MUL_R12,
        ST_MUL_C,
        ST_MUL_W,
        ST_DECIDE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    localparam logic [1:0] REG_JUMP  = 2'd0;
    localparam logic [1:0] REG_FAR   = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;
    localparam logic [1:0] REG_MIN   = 2'd3;

    function automatic logic signed [15:0] q30_to_q14(input logic signed [63:0] v);
        logic [63:0] m;
        begin
            if (v < 0)
            begin
                m = (64'(-v) + 64'd32768) >> 16;
                q30_to_q14 = -16'(signed'(m[15:0]));
            end
            else
            begin
                m = (64'(v) + 64'd32768) >> 16;
                q30_to_q14 = 16'(signed'(m[15:0]));
            end
        end
    endfunction

    function automatic logic signed [63:0] shr29(input logic signed [63:0] v);
        begin
            if (v < 0)
                shr29 = -64'(signed'(64'(-v) >> 29));
            else
                shr29 = 64'(signed'(64'(v) >> 29));
        end
    endfunction

    function automatic logic signed [15:0] cos_entry(input logic [9:0] k);
        logic signed [63:0] prev;
        logic signed [63:0] cur;
        logic signed [63:0] nxt;
        logic signed [15:0] res;
        begin
            prev = 64'sd1073741824;
            cur = 64'sd1073709056;
            res = q30_to_q14(prev);
            if (k == 10'd1)
                res = q30_to_q14(cur);
            for (int j = 2; j < CosSteps; j++)
            begin
                nxt = shr29(64'sd1073709056 * cur) - prev;
                prev = cur;
                cur = nxt;
                if (k == 10'(j))
                    res = q30_to_q14(cur);
            end
            cos_entry = res;
        end
    endfunction

endpackage

// ===== sv/laser_scan_leg_detector.sv =====
`timescale 1ns / 1ps
// Laser scan leg detector.
// Input channel: in_valid/in_stall with angle_code, distance_mm, last_point.
// Output channel: out_valid/out_stall with found, leg_index, leg_distance_mm.
// Config: cfg_we/cfg_index/cfg_data, written while idle.
// One item per accepted point; a result item only for a point marked last.
// Ordinary points pass from acceptance through ST_JUMP back to idle. A point
// that closes a long enough segment runs a 26-step restoring divider for
// the mean, then five steps on one shared 32x16 multiplier for the chord
// check; the multiplier steps are skipped if the mean is too far, and
// both if the segment is too short. The cosine table is a constant
// 1024-entry ROM. A last point's result is registered in ST_EMIT, after
// the full check when the point closes a segment.
// in_stall is high while an item is at work and while a result waits.
// The result is held in an output register until taken; the stalled
// result does not change. Reset restores register defaults and clears
// the scan.
module laser_scan_leg_detector (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] angle_code,
    input  logic [15:0]        distance_mm,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               found,
    output logic [9:0]         leg_index,
    output logic [15:0]        leg_distance_mm,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    lsld_pkg::state_t state_reg, state_next;

    logic [15:0] jump_reg, far_reg, width_reg;
    logic [10:0] min_reg;

    logic [lsld_pkg::CntW-1:0] cnt_reg;
    logic [15:0] pdist_reg;
    logic signed [15:0] pang_reg;
    logic open_reg;
    logic [9:0] start_reg;
    logic signed [15:0] fang_reg;
    logic [15:0] fdist_reg;
    logic [25:0] sum_reg;
    logic best_v_reg;
    logic [15:0] best_m_reg;
    logic [9:0] best_i_reg;

    logic signed [15:0] ang_reg;
    logic [15:0] dist_reg;
    logic last_reg;
    logic [9:0] close_reg;

    logic [25:0] quo_reg;
    logic [10:0] rem_reg;
    logic [10:0] n_reg;
    logic [4:0] step_reg;

    logic [47:0] acc_reg;
    logic [47:0] prod_reg;
    logic signed [15:0] cos_reg;
    logic [32:0] wsq_reg;

    logic out_v_reg, found_reg;
    logic [9:0] oi_reg;
    logic [15:0] od_reg;

    logic counting;
    logic [15:0] step_d;
    logic jump;
    logic [10:0] nval;
    logic [11:0] trial;
    logic [10:0] rem_sh;
    logic [16:0] theta;
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;
    logic signed [49:0] dval;
    logic [10:0] mid;

    assign counting = cnt_reg < lsld_pkg::CntW'(lsld_pkg::MaxPoints);
    assign step_d = (dist_reg > pdist_reg) ? dist_reg - pdist_reg : pdist_reg - dist_reg;
    assign jump = (cnt_reg != '0) && (step_d > jump_reg);
    assign nval = 11'(cnt_reg[9:0] - start_reg);
    assign rem_sh = {rem_reg[9:0], sum_reg[5'd25 - step_reg]};
    assign trial = {1'b0, rem_sh} - {1'b0, n_reg};
    assign theta = (fang_reg > pang_reg) ? 17'(fang_reg - pang_reg) : 17'(pang_reg - fang_reg);
    assign mid = 11'(start_reg) + 11'(close_reg);
    assign dval = signed'({2'b0, acc_reg});

    always_comb
    begin
        mul_a = {16'd0, fdist_reg};
        mul_b = fdist_reg;
        case (state_reg)
            lsld_pkg::ST_MUL_RR2:
            begin
                mul_a = {16'd0, pdist_reg};
                mul_b = pdist_reg;
            end
            lsld_pkg::ST_MUL_R12:
            begin
                mul_a = {16'd0, fdist_reg};
                mul_b = pdist_reg;
            end
            lsld_pkg::ST_MUL_C:
            begin
                mul_a = prod_reg[31:0];
                mul_b = cos_reg[15] ? 16'(-cos_reg) : 16'(cos_reg);
            end
            lsld_pkg::ST_MUL_W:
            begin
                mul_a = {16'd0, width_reg};
                mul_b = width_reg;
            end
            default:
            begin
                mul_a = {16'd0, fdist_reg};
                mul_b = fdist_reg;
            end
        endcase
    end
    assign mul_p = 48'(mul_a) * 48'(mul_b);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsld_pkg::ST_IDLE:
                if (in_valid && !out_v_reg)
                    state_next = lsld_pkg::ST_JUMP;
            lsld_pkg::ST_JUMP:
                if (!counting || !jump || !open_reg)
                    state_next = last_reg ? lsld_pkg::ST_EMIT : lsld_pkg::ST_IDLE;
                else if (nval == 11'd0 || nval < min_reg)
                    state_next = lsld_pkg::ST_UPDATE;
                else
                    state_next = lsld_pkg::ST_DIV;
            lsld_pkg::ST_DIV:
                if (step_reg == 5'd25)
                    state_next = lsld_pkg::ST_CHK_MEAN;
            lsld_pkg::ST_CHK_MEAN:
                state_next = (quo_reg > 26'(far_reg)) ? lsld_pkg::ST_UPDATE
                                                      : lsld_pkg::ST_MUL_RR1;
            lsld_pkg::ST_MUL_RR1: state_next = lsld_pkg::ST_MUL_RR2;
            lsld_pkg::ST_MUL_RR2: state_next = lsld_pkg::ST_MUL_R12;
            lsld_pkg::ST_MUL_R12: state_next = lsld_pkg::ST_MUL_C;
            lsld_pkg::ST_MUL_C:   state_next = lsld_pkg::ST_MUL_W;
            lsld_pkg::ST_MUL_W:   state_next = lsld_pkg::ST_DECIDE;
            lsld_pkg::ST_DECIDE:  state_next = lsld_pkg::ST_UPDATE;
            lsld_pkg::ST_UPDATE:
                state_next = last_reg ? lsld_pkg::ST_EMIT : lsld_pkg::ST_IDLE;
            lsld_pkg::ST_EMIT:
                if (!out_v_reg || !out_stall)
                    state_next = lsld_pkg::ST_IDLE;
            default: state_next = lsld_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        case (state_reg)
            lsld_pkg::ST_IDLE: in_stall = out_v_reg;
            default:           in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsld_pkg::ST_IDLE;
            jump_reg <= 16'd150;
            far_reg <= 16'd2000;
            width_reg <= 16'd1000;
            min_reg <= 11'd3;
            cnt_reg <= '0;
            pdist_reg <= '0;
            pang_reg <= '0;
            open_reg <= 1'b0;
            start_reg <= '0;
            fang_reg <= '0;
            fdist_reg <= '0;
            sum_reg <= '0;
            best_v_reg <= 1'b0;
            best_m_reg <= '0;
            best_i_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lsld_pkg::REG_JUMP:  jump_reg <= cfg_data;
                    lsld_pkg::REG_FAR:   far_reg <= cfg_data;
                    lsld_pkg::REG_WIDTH: width_reg <= cfg_data;
                    lsld_pkg::REG_MIN:   min_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (out_v_reg && !out_stall && state_reg != lsld_pkg::ST_EMIT)
                out_v_reg <= 1'b0;
            case (state_reg)
                lsld_pkg::ST_JUMP:
                    if (counting && !(jump && open_reg))
                    begin
                        if (jump)
                        begin
                            open_reg <= 1'b1;
                            start_reg <= cnt_reg[9:0];
                            fang_reg <= ang_reg;
                            fdist_reg <= dist_reg;
                            sum_reg <= 26'(dist_reg);
                        end
                        else if (open_reg)
                            sum_reg <= sum_reg + 26'(dist_reg);
                        pdist_reg <= dist_reg;
                        pang_reg <= ang_reg;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                lsld_pkg::ST_DECIDE:
                    if (!(dval > signed'(50'(wsq_reg) << 14)) &&
                        (!best_v_reg || quo_reg[15:0] < best_m_reg))
                    begin
                        best_v_reg <= 1'b1;
                        best_m_reg <= quo_reg[15:0];
                        best_i_reg <= mid[10:1];
                    end
                lsld_pkg::ST_UPDATE:
                begin
                    open_reg <= 1'b1;
                    start_reg <= cnt_reg[9:0];
                    fang_reg <= ang_reg;
                    fdist_reg <= dist_reg;
                    sum_reg <= 26'(dist_reg);
                    pdist_reg <= dist_reg;
                    pang_reg <= ang_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                lsld_pkg::ST_EMIT:
                    if (!out_v_reg || !out_stall)
                    begin
                        out_v_reg <= 1'b1;
                        cnt_reg <= '0;
                        pdist_reg <= '0;
                        pang_reg <= '0;
                        open_reg <= 1'b0;
                        start_reg <= '0;
                        fang_reg <= '0;
                        fdist_reg <= '0;
                        sum_reg <= '0;
                        best_v_reg <= 1'b0;
                        best_m_reg <= '0;
                        best_i_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lsld_pkg::ST_IDLE && in_valid && !in_stall)
        begin
            ang_reg <= angle_code;
            dist_reg <= distance_mm;
            last_reg <= last_point;
        end
        if (state_reg == lsld_pkg::ST_JUMP)
        begin
            close_reg <= cnt_reg[9:0];
            n_reg <= nval;
            step_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            cos_reg <= lsld_pkg::cos_entry(theta[15:6]);
        end
        if (state_reg == lsld_pkg::ST_DIV)
        begin
            step_reg <= step_reg + 1'b1;
            if (!trial[11])
            begin
                rem_reg <= trial[10:0];
                quo_reg <= {quo_reg[24:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[24:0], 1'b0};
            end
        end
        case (state_reg)
            lsld_pkg::ST_MUL_RR1:
                acc_reg <= mul_p << 14;
            lsld_pkg::ST_MUL_RR2:
                acc_reg <= acc_reg + (mul_p << 14);
            lsld_pkg::ST_MUL_R12:
                prod_reg <= mul_p;
            lsld_pkg::ST_MUL_C:
                if (cos_reg[15])
                    acc_reg <= acc_reg + (mul_p << 1);
                else
                    acc_reg <= acc_reg - (mul_p << 1);
            lsld_pkg::ST_MUL_W:
                wsq_reg <= 33'(mul_p);
            default: ;
        endcase
        if (state_reg == lsld_pkg::ST_EMIT && (!out_v_reg || !out_stall))
        begin
            found_reg <= best_v_reg;
            oi_reg <= best_v_reg ? best_i_reg : 10'd0;
            od_reg <= best_v_reg ? best_m_reg : 16'd0;
        end
    end

    assign out_valid = out_v_reg;
    assign found = found_reg;
    assign leg_index = oi_reg;
    assign leg_distance_mm = od_reg;

endmodule

// ===== sv/lsld_checker.sv =====
`timescale 1ns / 1ps
`include "laser_scan_leg_detector_macros.svh"
module lsld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        found,
    input logic [9:0]  leg_index,
    input logic [15:0] leg_distance_mm
);
    `LSLD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(leg_distance_mm))
    `LSLD_ASSERT_IMPL(a_zero, clk, rst_n, out_valid && !found, leg_index == 10'd0 && leg_distance_mm == 16'd0)
    `LSLD_ASSERT_NEXT(a_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    `LSLD_ASSERT_IMPL(a_wait, clk, rst_n, out_valid, in_stall)
endmodule

bind laser_scan_leg_detector lsld_checker u_lsld_checker (.*);

// ===== bench/laser_scan_leg_detector_test.sv =====
`timescale 1ns / 1ps
module laser_scan_leg_detector_test;

    localparam int WatchLimit = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] angle_code;
    logic [15:0]        distance_mm;
    logic               last_point;
    logic               out_valid;
    logic               out_stall;
    logic               found;
    logic [9:0]         leg_index;
    logic [15:0]        leg_distance_mm;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    laser_scan_leg_detector u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .angle_code(angle_code), .distance_mm(distance_mm), .last_point(last_point),
        .out_valid(out_valid), .out_stall(out_stall),
        .found(found), .leg_index(leg_index), .leg_distance_mm(leg_distance_mm),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic        found;
        logic [9:0]  index;
        logic [15:0] mean_mm;
    } leg_t;

    typedef struct {
        logic signed [15:0] ang;
        logic [15:0]        rng_mm;
        logic               last;
        logic               typed;
        leg_t               leg;
    } point_row_t;

    // predictor state
    logic [15:0] thr_jump, thr_far, thr_width;
    logic [10:0] min_pts;
    int unsigned n_pts;
    logic [15:0] prev_dist;
    logic signed [15:0] prev_ang;
    bit          seg_on;
    int unsigned seg_start;
    logic signed [15:0] seg_ang;
    logic [15:0] seg_dist;
    longint unsigned seg_sum;
    bit          have_leg;
    int unsigned leg_mean, leg_mid;
    longint      cos_tab [1024];

    leg_t legs_due [$];
    int   n_errors, n_results, n_found, n_points;
    int   idle_cycles;
    bit   hold_long;

    task automatic report(input string what, input longint got, input longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic longint round_q14(input longint v);
        if (v < 0)
            return -((-v + 32768) >>> 16);
        return (v + 32768) >>> 16;
    endfunction

    task automatic build_cosines();
        longint p, c, nx, t;
        p = 64'd1073741824;
        c = 64'd1073709056;
        cos_tab[0] = round_q14(p);
        cos_tab[1] = round_q14(c);
        for (int k = 2; k < 1024; k++)
        begin
            t = 64'd1073709056 * c;
            nx = ((t < 0) ? -((-t) >>> 29) : (t >>> 29)) - p;
            p = c;
            c = nx;
            cos_tab[k] = round_q14(c);
        end
    endtask

    task automatic clear_scan();
        n_pts = 0; prev_dist = 0; prev_ang = 0; seg_on = 0; seg_start = 0;
        seg_ang = 0; seg_dist = 0; seg_sum = 0; have_leg = 0; leg_mean = 0;
        leg_mid = 0;
    endtask

    task automatic close_seg(input int unsigned ci);
        int unsigned n, mean;
        int theta;
        longint r1, r2, c, d, w;
        n = ci - seg_start;
        if (n == 0 || n < min_pts)
            return;
        mean = seg_sum / n;
        if (mean > thr_far)
            return;
        theta = int'(seg_ang) - int'(prev_ang);
        if (theta < 0)
            theta = -theta;
        c = cos_tab[(theta >> 6) & 1023];
        r1 = seg_dist; r2 = prev_dist; w = thr_width;
        d = (r1 * r1 + r2 * r2) * 16384 - 2 * c * r1 * r2;
        if (d > w * w * 16384)
            return;
        if (!have_leg || mean < leg_mean)
        begin
            have_leg = 1;
            leg_mean = mean;
            leg_mid = (seg_start + ci) / 2;
        end
    endtask

    task automatic predict_point(input logic signed [15:0] a, input logic [15:0] r,
                                 input logic lst, output bit emits, output leg_t res);
        int unsigned stp;
        emits = 0;
        res = '0;
        if (n_pts < lsld_pkg::MaxPoints)
        begin
            if (n_pts > 0)
            begin
                stp = (r > prev_dist) ? r - prev_dist : prev_dist - r;
                if (stp > thr_jump)
                begin
                    if (seg_on)
                        close_seg(n_pts);
                    seg_on = 1; seg_start = n_pts; seg_ang = a; seg_dist = r; seg_sum = 0;
                end
            end
            if (seg_on)
                seg_sum = (seg_sum + r) & 64'h3ffffff;
            prev_dist = r;
            prev_ang = a;
            n_pts++;
        end
        if (lst)
        begin
            emits = 1;
            res.found = have_leg;
            res.index = have_leg ? leg_mid[9:0] : 10'd0;
            res.mean_mm = have_leg ? leg_mean[15:0] : 16'd0;
            clear_scan();
        end
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver
    initial
    begin
        int gap;
        out_stall = 1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_long)
            begin
                out_stall <= 1;
                repeat (600) @(posedge clk);
                hold_long = 0;
            end
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                  (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
            if (gap > 0)
            begin
                out_stall <= 1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    always @(posedge clk)
    begin
        leg_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (found)
                n_found++;
            if (legs_due.size() == 0)
                report("unexpected result", found, 0);
            else
            begin
                want = legs_due.pop_front();
                if (found !== want.found)
                    report("found", found, want.found);
                if (leg_index !== want.index)
                    report("leg_index", leg_index, want.index);
                if (leg_distance_mm !== want.mean_mm)
                    report("leg_distance_mm", leg_distance_mm, want.mean_mm);
            end
        end
    end

    task automatic send_point(input logic signed [15:0] a, input logic [15:0] r,
                              input logic lst, input bit typed, input leg_t typed_leg);
        bit emits;
        leg_t res;
        int gap;
        gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) :
              (($urandom_range(0, 2) == 0) ? $urandom_range(0, 2) : 0);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        angle_code <= a;
        distance_mm <= r;
        last_point <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_points++;
        predict_point(a, r, lst, emits, res);
        if (emits)
        begin
            if (typed && res !== typed_leg)
                report("typed row", res, typed_leg);
            legs_due.push_back(typed ? typed_leg : res);
        end
    endtask

    task automatic settle();
        @(posedge clk);
        in_valid <= 0;
        while (legs_due.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            lsld_pkg::REG_JUMP:  thr_jump = val;
            lsld_pkg::REG_FAR:   thr_far = val;
            lsld_pkg::REG_WIDTH: thr_width = val;
            default:             min_pts = val[10:0];
        endcase
    endtask

    // a scan of segments: plateaus separated by jumps
    task automatic send_scan(input int segs, input int seglen_max, input bit noisy);
        logic signed [15:0] a;
        logic [15:0] r;
        int len;
        a = 16'($urandom_range(0, 65535));
        r = 16'($urandom_range(200, 3000));
        for (int s = 0; s < segs; s++)
        begin
            len = $urandom_range(1, seglen_max);
            if (s > 0)
                r = 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(100, 4000));
            for (int k = 0; k < len; k++)
            begin
                a = a + 16'($urandom_range(0, noisy ? 4000 : 60));
                send_point(a, r + 16'($urandom_range(0, noisy ? 400 : 40)), 0, 0, '0);
            end
        end
        send_point(a, r, 1, 0, '0);
    endtask

    point_row_t rows [$];

    initial
    begin
        point_row_t row;
        n_errors = 0; n_results = 0; n_found = 0; n_points = 0; idle_cycles = 0;
        hold_long = 0;
        rst_n = 0; in_valid = 0; angle_code = 0; distance_mm = 0; last_point = 0;
        cfg_we = 0; cfg_index = lsld_pkg::REG_JUMP; cfg_data = 0;
        thr_jump = 150; thr_far = 2000; thr_width = 1000; min_pts = 3;
        build_cosines();
        clear_scan();
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed rows: lone last point, no jump, one clean leg, extremes
        rows = '{
            '{16'sd0, 16'd0, 1'b1, 1'b1, leg_t'{1'b0, 10'd0, 16'd0}},
            '{-16'sd32768, 16'd65535, 1'b1, 1'b1, leg_t'{1'b0, 10'd0, 16'd0}},
            '{16'sd0, 16'd500, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd1000, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd1000, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd1000, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd3000, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd3000, 1'b1, 1'b1, leg_t'{1'b1, 10'd2, 16'd1000}},
            '{16'sd32767, 16'd0, 1'b0, 1'b0, '0},
            '{-16'sd32768, 16'd65535, 1'b0, 1'b0, '0},
            '{16'sd32767, 16'd0, 1'b0, 1'b0, '0},
            '{16'sd100, 16'd1500, 1'b0, 1'b0, '0},
            '{16'sd120, 16'd1510, 1'b0, 1'b0, '0},
            '{16'sd140, 16'd1520, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd100, 1'b0, 1'b0, '0},
            '{16'sd0, 16'd100, 1'b1, 1'b0, '0}
        };
        foreach (rows[i])
        begin
            row = rows[i];
            send_point(row.ang, row.rng_mm, row.last, row.typed, row.leg);
        end
        settle();

        for (int phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0: begin write_reg(lsld_pkg::REG_JUMP, 16'd0);
                         write_reg(lsld_pkg::REG_MIN, 11'd0); end
                1: begin write_reg(lsld_pkg::REG_JUMP, 16'd65535);
                         write_reg(lsld_pkg::REG_FAR, 16'd0); end
                2: begin write_reg(lsld_pkg::REG_JUMP, 16'd150);
                         write_reg(lsld_pkg::REG_FAR, 16'd65535);
                         write_reg(lsld_pkg::REG_WIDTH, 16'd0);
                         write_reg(lsld_pkg::REG_MIN, 11'd1); end
                3: begin write_reg(lsld_pkg::REG_WIDTH, 16'd65535);
                         write_reg(lsld_pkg::REG_MIN, 11'd1024); end
                4: begin write_reg(lsld_pkg::REG_JUMP, 16'd150);
                         write_reg(lsld_pkg::REG_FAR, 16'd2000);
                         write_reg(lsld_pkg::REG_WIDTH, 16'd1000);
                         write_reg(lsld_pkg::REG_MIN, 11'd2); end
                5: begin write_reg(lsld_pkg::REG_JUMP, 16'($urandom_range(50, 600)));
                         write_reg(lsld_pkg::REG_FAR, 16'($urandom_range(500, 5000)));
                         write_reg(lsld_pkg::REG_WIDTH, 16'($urandom_range(100, 3000)));
                         write_reg(lsld_pkg::REG_MIN, 11'($urandom_range(1, 6))); end
                default: begin write_reg(lsld_pkg::REG_MIN, 11'd2047); end
            endcase
            if (phase == 4)
                hold_long = 1;
            for (int s = 0; s < 11; s++)
                send_scan($urandom_range(1, 6), $urandom_range(1, 8),
                          $urandom_range(0, 4) == 0);
            if (phase == 5)
            begin
                // overlong scan: points past the limit are dropped
                for (int k = 0; k < 1030; k++)
                    send_point(16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 1) ? 1000 : 1300), 0, 0, '0);
                send_point(16'sd0, 16'd0, 1, 0, '0);
            end
            settle();
        end

        $display("covered %0d points, %0d scan results (%0d with a leg)",
                 n_points, n_results, n_found);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
